>>> hw/rtl/trie_shortest_unique_prefix_core_macros.svh
// ============================================================================
// Trie prefix core assertion macros
// Shared concurrent assertion wrappers for the trie prefix core. Assertions
// compile away when SYNTHESIS is defined.
// ============================================================================
`ifndef TRIE_SHORTEST_UNIQUE_PREFIX_CORE_MACROS_SVH
`define TRIE_SHORTEST_UNIQUE_PREFIX_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion that is disabled while reset is asserted.
`define TSUP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("tsup assertion failed");

// Clocked assertion that is checked during reset as well.
`define TSUP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("tsup assertion failed");

`else

`define TSUP_ASSERT(lbl, clk, rstn, prop)
`define TSUP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> hw/rtl/tsup_pkg.sv
// ============================================================================
// Trie prefix core package
// Shared constants, status codes and controller/datapath interface types.
// ============================================================================
`default_nettype none

package tsup_pkg;

    // Default sizing of the trie.
    localparam int NODE_COUNT_DEF  = 32768;
    localparam int ALPHABET_DEF    = 26;
    localparam int COUNT_WIDTH_DEF = 11;

    // Fixed field widths.
    localparam int LETTER_W = 5;
    localparam int STATUS_W = 2;

    // Item kinds.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // latch the input beat and read the child slot
        logic check;    // read the node entry of the fetched child
        logic commit;   // apply the update and load the result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_result;   // the current item produces a result beat
        logic out_free;     // the output register can take a beat now
    } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/tsup_ctrl.sv
// ============================================================================
// Trie prefix core controller
// Three-state sequencer: accept and child read, node entry read, update.
// ============================================================================
`default_nettype none

`include "trie_shortest_unique_prefix_core_macros.svh"

module tsup_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire tsup_pkg::stat_t stat,
    output tsup_pkg::cmd_t      cmd
);
    import tsup_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_CHECK  = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Commands decoded from the state.
    always_comb begin
        cmd.accept = (state_reg == ST_IDLE) && s_valid;
        cmd.check  = (state_reg == ST_CHECK);
        cmd.commit = (state_reg == ST_UPDATE) && (!stat.has_result || stat.out_free);
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.accept) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // An accepted beat always moves on to the node read.
    `TSUP_ASSERT(a_accept_to_check, aclk, aresetn, cmd.accept |=> (state_reg == ST_CHECK))
    // The node read always moves on to the update.
    `TSUP_ASSERT(a_check_to_update, aclk, aresetn, cmd.check |=> (state_reg == ST_UPDATE))
    // The update waits only while a result is blocked by the output register.
    `TSUP_ASSERT(a_update_holds, aclk, aresetn, ((state_reg == ST_UPDATE) && !cmd.commit) |=> (state_reg == ST_UPDATE))

endmodule

`default_nettype wire

>>> hw/rtl/tsup_datapath.sv
// ============================================================================
// Trie prefix core datapath
// Child slot memory, node entry memory, word state and the output register.
// ============================================================================
`default_nettype none

`include "trie_shortest_unique_prefix_core_macros.svh"

module tsup_datapath #(
    parameter int NODE_COUNT  = tsup_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET    = tsup_pkg::ALPHABET_DEF,
    parameter int COUNT_WIDTH = tsup_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire tsup_pkg::cmd_t             cmd,
    output tsup_pkg::stat_t                 stat,
    input  wire logic                       s_kind,
    input  wire logic [tsup_pkg::LETTER_W-1:0] s_letter,
    input  wire logic                       s_word_end,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [tsup_pkg::LETTER_W-1:0]   m_out_letter,
    output logic                            m_last,
    output logic [tsup_pkg::STATUS_W-1:0]   m_status
);
    import tsup_pkg::*;

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int NF_W    = $clog2(NODE_COUNT + 1);
    localparam int SLOTS   = NODE_COUNT * ALPHABET;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ENTRY_W = NODE_W + LETTER_W + COUNT_WIDTH;

    // Child slots hold a node index; node entries hold parent, letter and count.
    logic [NODE_W-1:0]  child_mem [SLOTS];
    logic [ENTRY_W-1:0] node_mem  [NODE_COUNT];

    // Word state.
    logic [NODE_W-1:0] current_node_reg, current_node_next;
    logic [NF_W-1:0]   next_free_reg, next_free_next;
    logic              word_done_reg, word_done_next;
    status_t           word_status_reg, word_status_next;

    // Item and read data registers.
    logic                kind_reg;
    logic [LETTER_W-1:0] letter_reg;
    logic                fin_reg;
    logic                letter_ok_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [NODE_W-1:0]   child_q_reg;
    logic [ENTRY_W-1:0]  node_q_reg;

    // Output register.
    logic                m_valid_reg;
    logic [LETTER_W-1:0] m_letter_reg;
    logic                m_last_reg;
    status_t             m_status_reg;

    // Child slot address of the incoming beat.
    logic              in_letter_ok;
    logic [SLOT_W-1:0] slot_calc;
    logic [SLOT_W-1:0] slot_rd;

    assign in_letter_ok = (32'(s_letter) < ALPHABET);
    assign slot_calc    = SLOT_W'(SLOT_W'(current_node_reg) * SLOT_W'(ALPHABET))
                        + SLOT_W'(s_letter);
    assign slot_rd      = in_letter_ok ? slot_calc : '0;

    // Node entry address of the fetched child.
    logic [NODE_W-1:0] node_rd;

    assign node_rd = (32'(child_q_reg) < NODE_COUNT) ? child_q_reg : '0;

    // Fields of the fetched node entry.
    logic [NODE_W-1:0]      q_parent;
    logic [LETTER_W-1:0]    q_letter;
    logic [COUNT_WIDTH-1:0] q_count;
    logic [COUNT_WIDTH-1:0] count_inc;

    assign q_parent  = node_q_reg[ENTRY_W-1 -: NODE_W];
    assign q_letter  = node_q_reg[COUNT_WIDTH +: LETTER_W];
    assign q_count   = node_q_reg[COUNT_WIDTH-1:0];
    assign count_inc = (q_count == '1) ? q_count : q_count + COUNT_WIDTH'(1);

    // A slot is a real child only if the node it names was allocated since reset
    // and points back at this parent and letter; stale memory contents fail this.
    logic child_hit;
    logic store_room;

    assign child_hit  = letter_ok_reg && (child_q_reg != '0)
                     && (NF_W'(child_q_reg) < next_free_reg)
                     && (q_parent == current_node_reg) && (q_letter == letter_reg);
    assign store_room = (next_free_reg < NF_W'(NODE_COUNT));

    // Update decision for the current item.
    logic               res;
    logic               res_last;
    status_t            res_status;
    logic               wr_child;
    logic               wr_node;
    logic [NODE_W-1:0]  node_wr_addr;
    logic [ENTRY_W-1:0] node_wr_data;
    logic               end_word;

    always_comb begin
        current_node_next = current_node_reg;
        next_free_next    = next_free_reg;
        word_done_next    = word_done_reg;
        word_status_next  = word_status_reg;
        res               = 1'b0;
        res_last          = 1'b0;
        res_status        = STATUS_OK;
        wr_child          = 1'b0;
        wr_node           = 1'b0;
        node_wr_addr      = child_q_reg;
        node_wr_data      = {q_parent, q_letter, count_inc};
        end_word          = 1'b0;

        if (kind_reg == KIND_INSERT) begin
            // Insert: follow or allocate the child and raise its count, or mark the word full.
            if (letter_ok_reg && (word_status_reg == STATUS_OK)) begin
                if (child_hit) begin
                    current_node_next = child_q_reg;
                    wr_node           = 1'b1;
                end else if (store_room) begin
                    wr_child          = 1'b1;
                    wr_node           = 1'b1;
                    node_wr_addr      = next_free_reg[NODE_W-1:0];
                    node_wr_data      = {current_node_reg, letter_reg, COUNT_WIDTH'(1)};
                    next_free_next    = next_free_reg + NF_W'(1);
                    current_node_next = next_free_reg[NODE_W-1:0];
                end else begin
                    word_status_next = STATUS_FULL;
                end
            end
            if (fin_reg) begin
                res        = 1'b1;
                res_last   = 1'b1;
                res_status = word_status_next;
                end_word   = 1'b1;
            end
        end else begin
            // Query: echo letters until the prefix becomes unique. A slot that
            // was never written falls through to the not-found arm.
            if (word_done_reg) begin
                end_word = fin_reg;
            end else if (child_hit) begin
                current_node_next = child_q_reg;
                res      = 1'b1;
                res_last = fin_reg || (q_count == COUNT_WIDTH'(1));
                end_word = fin_reg;
                word_done_next = res_last;
            end else begin
                res        = 1'b1;
                res_last   = 1'b1;
                res_status = STATUS_NOT_FOUND;
                end_word   = fin_reg;
                word_done_next = 1'b1;
            end
        end

        // The end of a word returns to the root.
        if (end_word) begin
            current_node_next = '0;
            word_done_next    = 1'b0;
            word_status_next  = STATUS_OK;
        end
    end

    assign stat.has_result = res;
    assign stat.out_free   = !m_valid_reg || m_ready;

    // Memory reads and writes.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            child_q_reg <= child_mem[slot_rd];
        end
        if (cmd.check) begin
            node_q_reg <= node_mem[node_rd];
        end
        if (cmd.commit && wr_child) begin
            child_mem[slot_reg] <= next_free_reg[NODE_W-1:0];
        end
        if (cmd.commit && wr_node) begin
            node_mem[node_wr_addr] <= node_wr_data;
        end
    end

    // Input beat capture.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg      <= s_kind;
            letter_reg    <= s_letter;
            fin_reg       <= s_word_end;
            letter_ok_reg <= in_letter_ok;
            slot_reg      <= slot_rd;
        end
    end

    // Word state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_node_reg <= '0;
            next_free_reg    <= NF_W'(1);
            word_done_reg    <= 1'b0;
            word_status_reg  <= STATUS_OK;
        end else if (cmd.commit) begin
            current_node_reg <= current_node_next;
            next_free_reg    <= next_free_next;
            word_done_reg    <= word_done_next;
            word_status_reg  <= word_status_next;
        end
    end

    // Output register valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit && res) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (cmd.commit && res) begin
            m_letter_reg <= letter_reg;
            m_last_reg   <= res_last;
            m_status_reg <= res_status;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_letter = m_letter_reg;
    assign m_last       = m_last_reg;
    assign m_status     = m_status_reg;

    // The allocation pointer stays within the node store.
    `TSUP_ASSERT(a_next_free_range, aclk, aresetn, (next_free_reg != '0) && (next_free_reg <= NF_W'(NODE_COUNT)))
    // The word always sits on an allocated node.
    `TSUP_ASSERT(a_current_allocated, aclk, aresetn, NF_W'(current_node_reg) < next_free_reg)
    // A result is never loaded over a beat that has not been taken.
    `TSUP_ASSERT(a_no_overwrite, aclk, aresetn, (cmd.commit && res) |-> (!m_valid_reg || m_ready))

endmodule

`default_nettype wire

>>> hw/rtl/trie_shortest_unique_prefix_core.sv
// Shortest unique prefix trie core. Words stream in one letter per input beat,
// each beat tagged insert or query and flagged on the word's last letter. Each
// letter is handled in steps: the child slot is read as the beat is accepted,
// the child's node entry (parent, letter, pass count) is read in the check
// state, and the update and result load happen in the update state, which
// waits while an earlier result beat is still held in the output register. No
// clearing pass is needed after reset: a child slot counts as present only
// when the node it names has been allocated since reset and its entry points
// back at the same parent and letter, so stale memory contents are never
// trusted.
// ============================================================================
// Trie prefix core top level
// Joins the controller and the datapath and exposes the two beat channels.
// ============================================================================
`default_nettype none

module trie_shortest_unique_prefix_core #(
    parameter int NODE_COUNT  = tsup_pkg::NODE_COUNT_DEF,
    parameter int ALPHABET    = tsup_pkg::ALPHABET_DEF,
    parameter int COUNT_WIDTH = tsup_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_kind,
    input  wire logic [tsup_pkg::LETTER_W-1:0] s_letter,
    input  wire logic                          s_word_end,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [tsup_pkg::LETTER_W-1:0]      m_out_letter,
    output logic                               m_last,
    output logic [tsup_pkg::STATUS_W-1:0]      m_status
);
    import tsup_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    tsup_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Trie storage and word state.
    tsup_datapath #(
        .NODE_COUNT  (NODE_COUNT),
        .ALPHABET    (ALPHABET),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_kind       (s_kind),
        .s_letter     (s_letter),
        .s_word_end   (s_word_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_letter (m_out_letter),
        .m_last       (m_last),
        .m_status     (m_status)
    );

endmodule

`default_nettype wire

>>> bench/tb_trie_prefix_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Trie prefix scoreboard
// Keeps its own copy of the trie, works out the result beats that each
// accepted letter causes, and checks the beats that leave the core in order.
// ============================================================================
package tb_trie_prefix_pkg;
    import tsup_pkg::*;

    localparam int          TRIE_NODES   = NODE_COUNT_DEF;
    localparam int          TRIE_LETTERS = ALPHABET_DEF;
    localparam int unsigned COUNT_CEIL   = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int          MAX_PRINTED  = 100;

    typedef logic [LETTER_W-1:0] letter_t;

    typedef struct packed {
        letter_t letter;
        logic    last;
        status_t status;
    } prefix_beat_t;

    class prefix_trie_scoreboard;
        // Trie copy: child links keyed by node and letter, pass counts by node.
        int           child_slot[int];
        int unsigned  pass_cnt[int];
        int           next_node;
        int           cur_node;
        bit           prefix_done;
        status_t      word_stat;
        prefix_beat_t beats_due[$];

        int mismatches;
        int beats_checked;
        int not_found_seen;
        int full_seen;
        int unique_cuts;
        int insert_words;
        int query_words;

        function new();
            next_node      = 1;
            cur_node       = 0;
            prefix_done    = 1'b0;
            word_stat      = STATUS_OK;
            mismatches     = 0;
            beats_checked  = 0;
            not_found_seen = 0;
            full_seen      = 0;
            unique_cuts    = 0;
            insert_words   = 0;
            query_words    = 0;
        endfunction

        function int free_nodes();
            return TRIE_NODES - next_node;
        endfunction

        function int pending();
            return beats_due.size();
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_PRINTED) begin
                $display("mismatch @%0t: %s", $time, what);
            end
            mismatches++;
        endtask

        function void expect_beat(letter_t letter, logic last, status_t status);
            prefix_beat_t due;
            due.letter = letter;
            due.last   = last;
            due.status = status;
            beats_due.push_back(due);
        endfunction

        // Any word end sends the walk back to the root.
        function void close_word(logic kind);
            if (kind == KIND_INSERT) begin
                insert_words++;
            end else begin
                query_words++;
            end
            cur_node    = 0;
            prefix_done = 1'b0;
            word_stat   = STATUS_OK;
        endfunction

        // Child of the current node under a letter; zero when absent.
        function int child_at(letter_t letter);
            int slot;
            slot = cur_node * TRIE_LETTERS + int'(letter);
            if (int'(letter) >= TRIE_LETTERS || !child_slot.exists(slot)) begin
                return 0;
            end
            return child_slot[slot];
        endfunction

        // Walks one accepted letter through the trie copy.
        function void note_letter(logic kind, letter_t letter, logic word_end);
            int child;
            bit stop;
            child = child_at(letter);

            if (kind == KIND_INSERT) begin
                // Letters outside the alphabet and words that ran out of nodes
                // leave the trie alone.
                if (int'(letter) < TRIE_LETTERS && word_stat == STATUS_OK) begin
                    if (child == 0) begin
                        if (next_node < TRIE_NODES) begin
                            child = next_node;
                            next_node++;
                            pass_cnt[child] = 0;
                            child_slot[cur_node * TRIE_LETTERS + int'(letter)] = child;
                        end else begin
                            word_stat = STATUS_FULL;
                        end
                    end
                    if (child != 0) begin
                        cur_node = child;
                        if (pass_cnt[child] < COUNT_CEIL) begin
                            pass_cnt[child]++;
                        end
                    end
                end
                if (word_end) begin
                    expect_beat(letter, 1'b1, word_stat);
                    if (word_stat == STATUS_FULL) begin
                        full_seen++;
                    end
                    close_word(kind);
                end
                return;
            end

            // Query letters after the prefix is complete are dropped.
            if (prefix_done) begin
                if (word_end) begin
                    close_word(kind);
                end
                return;
            end

            if (child == 0) begin
                expect_beat(letter, 1'b1, STATUS_NOT_FOUND);
                not_found_seen++;
                if (word_end) begin
                    close_word(kind);
                end else begin
                    prefix_done = 1'b1;
                end
                return;
            end

            cur_node = child;
            stop     = word_end || pass_cnt[child] == 1;
            expect_beat(letter, stop, STATUS_OK);
            if (word_end) begin
                close_word(kind);
            end else if (stop) begin
                prefix_done = 1'b1;
                unique_cuts++;
            end
        endfunction

        // Compares one result beat with the oldest one due.
        task check_prefix_beat(letter_t letter, logic last, logic [STATUS_W-1:0] status);
            prefix_beat_t due;
            if (beats_due.size() == 0) begin
                report_mismatch($sformatf("result beat letter=%0d last=%0b status=%0d, none due",
                                          letter, last, status));
                return;
            end
            due = beats_due.pop_front();
            beats_checked++;
            if (letter !== due.letter) begin
                report_mismatch($sformatf("beat %0d: letter %0d, expected %0d",
                                          beats_checked, letter, due.letter));
            end
            if (last !== due.last) begin
                report_mismatch($sformatf("beat %0d: last %0b, expected %0b",
                                          beats_checked, last, due.last));
            end
            if (status !== due.status) begin
                report_mismatch($sformatf("beat %0d: status %0d, expected %0d",
                                          beats_checked, status, due.status));
            end
        endtask

        task finish_check();
            if (beats_due.size() != 0) begin
                report_mismatch($sformatf("%0d result beats never arrived", beats_due.size()));
            end
        endtask
    endclass

endpackage

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Trie prefix core testbench
// Streams insert and query words through the core under random pacing and
// back-pressure, and checks every result beat against the scoreboard's own
// trie.
// ============================================================================
module tb_top;
    import tsup_pkg::*;
    import tb_trie_prefix_pkg::*;

    localparam int      WORD_MAX         = 12;
    localparam int      RANDOM_BEATS     = 1330;
    localparam int      HOLD_AFTER_BEATS = 500;
    localparam int      HOLD_CYCLES      = 300;
    localparam letter_t LETTER_TOP       = '1;

    // One word: per-letter kind, letter codes and length.
    typedef struct packed {
        logic [WORD_MAX-1:0]               kinds;
        logic [WORD_MAX-1:0][LETTER_W-1:0] code;
        logic [3:0]                        len;
    } word_t;

    logic                aclk       = 1'b0;
    logic                aresetn    = 1'b0;
    logic                s_valid    = 1'b0;
    wire                 s_ready;
    logic                s_kind     = KIND_INSERT;
    logic [LETTER_W-1:0] s_letter   = '0;
    logic                s_word_end = 1'b0;
    wire                 m_valid;
    logic                m_ready    = 1'b0;
    wire [LETTER_W-1:0]  m_out_letter;
    wire                 m_last;
    wire [STATUS_W-1:0]  m_status;

    prefix_trie_scoreboard sb = new();

    bit    pace_on        = 1'b1;
    int    burst_left     = 0;
    int    beats_accepted = 0;
    word_t dict[$];

    trie_shortest_unique_prefix_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_letter     (s_letter),
        .s_word_end   (s_word_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_letter (m_out_letter),
        .m_last       (m_last),
        .m_status     (m_status)
    );

    always #10 aclk = ~aclk;

    // Hard stop in case the core hangs.
    initial begin : watchdog
        #30ms;
        $display("status: fail");
        $finish;
    end

    function automatic letter_t ch(byte c);
        return letter_t'(c - "a");
    endfunction

    // Offers one beat and waits for it to be taken; bursts end in random gaps.
    task automatic send_beat(input logic kind, input letter_t letter, input logic word_end);
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_letter   <= letter;
        s_word_end <= word_end;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_letter(kind, letter, word_end);
        beats_accepted++;
        if (pace_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 11);
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge aclk);
            end
        end
    endtask

    task automatic send_word(input word_t w);
        for (int i = 0; i < int'(w.len); i++) begin
            send_beat(w.kinds[i], w.code[i], i == int'(w.len) - 1);
        end
    endtask

    // Narrow words lean on a few letters so that prefixes are shared.
    function automatic word_t random_word(input int len, input bit wide, input logic kind);
        word_t w;
        w.kinds = {WORD_MAX{kind}};
        w.len   = 4'(len);
        for (int i = 0; i < WORD_MAX; i++) begin
            if (wide || $urandom_range(0, 9) < 3) begin
                w.code[i] = letter_t'($urandom_range(0, TRIE_LETTERS - 1));
            end else begin
                w.code[i] = letter_t'($urandom_range(0, 5));
            end
        end
        return w;
    endfunction

    function automatic int random_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(7, WORD_MAX);
        end
        return $urandom_range(1, 5);
    endfunction

    // One random word: mostly inserts and queries of known words, some noise.
    task automatic send_random_word();
        word_t w;
        int    pick;
        pick    = $urandom_range(0, 99);
        pace_on = ($urandom_range(0, 3) != 0);
        if (pick < 40 || dict.size() == 0) begin
            if (pick < 6 && dict.size() != 0) begin
                w = dict[$urandom_range(0, dict.size() - 1)];
            end else begin
                w = random_word(random_len(), 1'b0, KIND_INSERT);
                dict.push_back(w);
            end
            w.kinds = {WORD_MAX{KIND_INSERT}};
        end else if (pick < 90) begin
            w = dict[$urandom_range(0, dict.size() - 1)];
            if (pick < 55) begin
                // Known word as inserted.
            end else if (pick < 65) begin
                w.len = 4'($urandom_range(1, w.len));
            end else if (pick < 72) begin
                if (w.len < WORD_MAX) begin
                    w.len = w.len + 4'd1;
                end
            end else if (pick < 80) begin
                w.code[w.len - 1] = letter_t'($urandom_range(0, TRIE_LETTERS - 1));
            end else begin
                w = random_word(random_len(), 1'b0, KIND_QUERY);
            end
            w.kinds = {WORD_MAX{KIND_QUERY}};
        end else begin
            // Mixed kinds, often with a letter outside the alphabet.
            w       = random_word(random_len(), 1'b0, KIND_INSERT);
            w.kinds = WORD_MAX'($urandom);
            if (pick < 96) begin
                w.code[$urandom_range(0, w.len - 1)] =
                    letter_t'($urandom_range(TRIE_LETTERS, int'(LETTER_TOP)));
            end
        end
        send_word(w);
    endtask

    // Result side: samples at the rising edge, changes ready at the falling one.
    initial begin : result_sink
        int mode_left;
        int rx_mode;
        int run_left;
        int hold_left;
        bit run_ready;
        bit held;
        mode_left = 0;
        rx_mode   = 0;
        run_left  = 0;
        hold_left = 0;
        run_ready = 1'b0;
        held      = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid === 1'b1 && m_ready === 1'b1) begin
                sb.check_prefix_beat(m_out_letter, m_last, m_status);
            end
            @(negedge aclk);
            // One long hold-off so that the core backs up into its input.
            if (!held && beats_accepted >= HOLD_AFTER_BEATS) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 160);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        if (run_left == 0) begin
                            run_ready = !run_ready;
                            run_left  = $urandom_range(1, 8);
                        end else begin
                            run_left--;
                        end
                        m_ready <= run_ready;
                    end
                endcase
            end
        end
    end

    initial begin : stimulus
        word_t w;
        int    start_beats;
        int    guard;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Query on the empty trie.
        send_beat(KIND_QUERY, ch("b"), 1'b1);
        // Build "az" and "ab" so that node a is shared.
        send_beat(KIND_INSERT, ch("a"), 1'b0);
        send_beat(KIND_INSERT, ch("z"), 1'b1);
        send_beat(KIND_INSERT, ch("a"), 1'b0);
        send_beat(KIND_INSERT, ch("b"), 1'b1);
        // Unique node reached early; the trailing letter is dropped.
        send_beat(KIND_QUERY, ch("a"), 1'b0);
        send_beat(KIND_QUERY, ch("z"), 1'b0);
        send_beat(KIND_QUERY, ch("q"), 1'b1);
        // Word ends on a shared node.
        send_beat(KIND_QUERY, ch("a"), 1'b1);
        // Missing child after a shared node, then at the root with more letters.
        send_beat(KIND_QUERY, ch("a"), 1'b0);
        send_beat(KIND_QUERY, ch("c"), 1'b1);
        send_beat(KIND_QUERY, ch("c"), 1'b0);
        send_beat(KIND_QUERY, ch("d"), 1'b0);
        send_beat(KIND_QUERY, ch("e"), 1'b1);
        // Letters outside the alphabet for both kinds.
        send_beat(KIND_INSERT, ch("a"), 1'b0);
        send_beat(KIND_INSERT, LETTER_TOP, 1'b1);
        send_beat(KIND_QUERY, LETTER_TOP, 1'b1);
        send_beat(KIND_QUERY, ch("a"), 1'b0);
        send_beat(KIND_QUERY, letter_t'(LETTER_TOP - 1'b1), 1'b0);
        send_beat(KIND_QUERY, ch("b"), 1'b1);
        // Kinds mixed within one word.
        send_beat(KIND_INSERT, ch("k"), 1'b0);
        send_beat(KIND_QUERY, ch("l"), 1'b1);

        // Random words with random pacing.
        start_beats = beats_accepted;
        while (beats_accepted - start_beats < RANDOM_BEATS) begin
            send_random_word();
        end

        // Known words again, with one kind picked for the whole word.
        pace_on = 1'b0;
        repeat (20) begin
            w       = dict[$urandom_range(0, dict.size() - 1)];
            w.kinds = {WORD_MAX{logic'($urandom_range(0, 1))}};
            send_word(w);
        end
        repeat (60) send_random_word();

        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain the outstanding results, then allow stray beats to show up.
        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (20) @(posedge aclk);
        sb.finish_check();

        $display("Covered %0d insert words and %0d query words in %0d beats; %0d checked.",
                 sb.insert_words, sb.query_words, beats_accepted, sb.beats_checked);
        $display("Included %0d early unique prefixes and %0d missing paths.",
                 sb.unique_cuts, sb.not_found_seen);
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
